// ===== rtl/core/rte_pkg.sv =====
`default_nettype none

package rte_pkg;

   localparam int MAX_LEVELS = 8;
   localparam int FRAC_BITS  = 32;

   localparam int DATA_W  = 64;
   localparam int HALF_W  = DATA_W / 2;
   localparam int CFG_W   = 4;
   localparam int ROWF_W  = 3;
   localparam int ROW_W   = $clog2(MAX_LEVELS);
   localparam int LVL_W   = $clog2(MAX_LEVELS + 1);
   localparam int RECIP_W = FRAC_BITS;

   localparam logic [CFG_W-1:0] LEVEL_RESET = CFG_W'(MAX_LEVELS);

   // one tableau entry moving down the chain; left counts the columns still to build
   typedef struct packed {
      logic              valid;
      logic [ROW_W-1:0]  left;
      logic [DATA_W-1:0] value;
   } token_type;

endpackage

`default_nettype wire

// ===== rtl/core/romberg_extrapolation_tableau.sv =====
`default_nettype none
// The estimate of tableau row i shows on rsp once its request has passed entry_ff and cells
// 0 to i-1; each column of the row is built by one cell, through that cell's stages a to e.
// One item at a time: a request is taken only while no item is in flight and the hold slot
// is empty. A finished result may wait in the output register while the next item runs.
// Reset (synchronous) clears the row counter, sets level_count to 8 and empties the
// pipeline; the stored previous row is not cleared, it is written before it is read.

module romberg_extrapolation_tableau (
   input  wire         clock,
   input  wire         reset,
   // configuration: level_count
   input  wire         csr_wr_en,
   input  wire  [3:0]  csr_wr_data,
   // request: [63:0] column_value
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire  [63:0] req_tdata,
   // response: [63:0] estimate
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [63:0] rsp_tdata,
   // response user: [2:0] row_index
   output logic [2:0]  rsp_tuser,
   // response last: done_res, final row of the run
   output logic        rsp_tlast
);
   import rte_pkg::*;

   // configuration and row sequencing
   logic [CFG_W-1:0] level_ff;
   logic [ROW_W-1:0] row_cnt_ff;
   logic [LVL_W-1:0] levels_eff;
   logic [ROW_W-1:0] last_row;
   logic [ROW_W-1:0] row_sel;
   logic             row_done;
   logic             accept;

   // item in flight and its metadata
   logic             busy_ff;
   logic [ROW_W-1:0] meta_row_ff;
   logic             meta_done_ff;
   token_type        entry_ff;

   // cell chain
   token_type                     chain [MAX_LEVELS+1];
   logic [MAX_LEVELS-1:0]         fin_valid;
   logic [DATA_W-1:0]             fin_value [MAX_LEVELS];
   logic                          any_fin;
   logic [DATA_W-1:0]             fin_data;

   // output register plus one hold slot
   logic              rsp_valid_ff;
   logic [DATA_W-1:0] rsp_data_ff;
   logic [ROW_W-1:0]  rsp_row_ff;
   logic              rsp_last_ff;
   logic              hold_valid_ff;
   logic [DATA_W-1:0] hold_data_ff;
   logic [ROW_W-1:0]  hold_row_ff;
   logic              hold_last_ff;
   logic              rsp_free;

   // clamp level_count into 1..MAX_LEVELS
   always_comb begin
      priority if (level_ff == '0) begin
         levels_eff = LVL_W'(1);
      end else if (int'(level_ff) > MAX_LEVELS) begin
         levels_eff = LVL_W'(MAX_LEVELS);
      end else begin
         levels_eff = LVL_W'(level_ff);
      end
   end

   // a counter left past the final row by a level change lands on the final row
   assign last_row = ROW_W'(levels_eff - LVL_W'(1));
   assign row_sel  = (row_cnt_ff >= last_row) ? last_row : row_cnt_ff;
   assign row_done = (row_sel == last_row);

   assign req_tready = !busy_ff && !hold_valid_ff;
   assign accept     = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         level_ff   <= LEVEL_RESET;
         row_cnt_ff <= '0;
         busy_ff    <= 1'b0;
         entry_ff.valid <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            level_ff <= csr_wr_data;
         end
         if (accept) begin
            row_cnt_ff     <= row_done ? '0 : row_sel + ROW_W'(1);
            entry_ff.left  <= row_sel;
            entry_ff.value <= req_tdata;
         end
         // set on a request transaction, drop once the diagonal entry leaves the chain
         if (accept) begin
            busy_ff <= 1'b1;
         end else if (any_fin) begin
            busy_ff <= 1'b0;
         end
         entry_ff.valid <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         meta_row_ff    <= row_sel;
         meta_done_ff   <= row_done;
      end
   end

   assign chain[0] = entry_ff;

   // cell k keeps previous_row[k] and builds column k+1 with 1/(4^(k+1)-1)
   for (genvar k = 0; k < MAX_LEVELS; k++) begin : g_cell
      localparam longint unsigned Div   = (64'd1 << (2 * (k + 1))) - 64'd1;
      localparam longint unsigned Recip = ((64'd1 << FRAC_BITS) + Div / 2) / Div;

      rte_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .recip     (RECIP_W'(Recip)),
         .tok_in    (chain[k]),
         .tok_out   (chain[k+1]),
         .fin_valid (fin_valid[k]),
         .fin_value (fin_value[k])
      );
   end

   // only the cell holding the diagonal entry raises fin_valid, so OR the lanes
   always_comb begin
      fin_data = '0;
      for (int k = 0; k < MAX_LEVELS; k++) begin
         fin_data = fin_data | (fin_value[k] & {DATA_W{fin_valid[k]}});
      end
   end
   assign any_fin = |fin_valid;

   assign rsp_free = !rsp_valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         hold_valid_ff <= 1'b0;
      end else begin
         if (rsp_free) begin
            // advance the held result first; nothing finishes while it waits
            rsp_valid_ff  <= hold_valid_ff || any_fin;
            hold_valid_ff <= 1'b0;
         end else if (any_fin) begin
            hold_valid_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_free) begin
         if (hold_valid_ff) begin
            rsp_data_ff <= hold_data_ff;
            rsp_row_ff  <= hold_row_ff;
            rsp_last_ff <= hold_last_ff;
         end else begin
            rsp_data_ff <= fin_data;
            rsp_row_ff  <= meta_row_ff;
            rsp_last_ff <= meta_done_ff;
         end
      end
      if (!rsp_free && any_fin) begin
         hold_data_ff <= fin_data;
         hold_row_ff  <= meta_row_ff;
         hold_last_ff <= meta_done_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = ROWF_W'(rsp_row_ff);
   assign rsp_tlast  = rsp_last_ff;

   // a held result always sits behind an occupied output register
   a_hold_behind_rsp : assert property (@(posedge clock) disable iff (reset)
      hold_valid_ff |-> rsp_valid_ff)
      else $error("hold slot filled while output register empty");

   // the chain finishes only an item that was accepted and is still in flight
   a_fin_while_busy : assert property (@(posedge clock) disable iff (reset)
      any_fin |-> busy_ff)
      else $error("diagonal entry with no item in flight");

   // one item at a time: at most one cell holds a diagonal entry
   a_fin_onehot : assert property (@(posedge clock) disable iff (reset)
      $onehot0(fin_valid))
      else $error("more than one cell finished in the same cycle");

   // a finished entry is never lost: it lands in the output register or the hold slot
   a_fin_captured : assert property (@(posedge clock) disable iff (reset)
      any_fin |=> (rsp_valid_ff || hold_valid_ff))
      else $error("finished result dropped");

endmodule

`default_nettype wire

// ===== rtl/core/rte_cell.sv =====
`default_nettype none

module rte_cell (
   input  wire                       clock,
   input  wire                       reset,
   input  wire  [rte_pkg::RECIP_W-1:0] recip,
   input  wire  rte_pkg::token_type  tok_in,
   output rte_pkg::token_type        tok_out,
   output logic                      fin_valid,
   output logic [rte_pkg::DATA_W-1:0] fin_value
);
   import rte_pkg::*;

   localparam int PROD_W = HALF_W + RECIP_W;
   localparam int SUM_W  = DATA_W + RECIP_W + 1;
   localparam logic [SUM_W-1:0] ROUND_HALF = SUM_W'(1) << (FRAC_BITS - 1);
   localparam logic [DATA_W-1:0] SAT_MAX = {1'b0, {(DATA_W-1){1'b1}}};
   localparam logic [DATA_W-1:0] SAT_MIN = {1'b1, {(DATA_W-1){1'b0}}};

   logic [DATA_W-1:0] prev_ff;

   // stage a: difference magnitude and sign
   logic              a_valid_ff;
   logic [ROW_W-1:0]  a_left_ff;
   logic [DATA_W-1:0] a_base_ff, a_mag_ff;
   logic              a_neg_ff;
   logic [DATA_W:0]   diff_in;
   logic [DATA_W-1:0] mag_in;
   logic              start_in;

   // stage b: low partial product
   logic              b_valid_ff;
   logic [ROW_W-1:0]  b_left_ff;
   logic [DATA_W-1:0] b_base_ff;
   logic              b_neg_ff;
   logic [HALF_W-1:0] b_mhi_ff;
   logic [PROD_W-1:0] b_plo_ff;

   // stage c: high partial product
   logic              c_valid_ff;
   logic [ROW_W-1:0]  c_left_ff;
   logic [DATA_W-1:0] c_base_ff;
   logic              c_neg_ff;
   logic [PROD_W-1:0] c_plo_ff, c_phi_ff;

   // stage d: rounded scaled term
   logic              d_valid_ff;
   logic [ROW_W-1:0]  d_left_ff;
   logic [DATA_W-1:0] d_base_ff;
   logic              d_neg_ff;
   logic [DATA_W-1:0] d_q_ff;
   logic [SUM_W-1:0]  sum_in;

   // stage e: saturating add
   logic [DATA_W-1:0] res_in;
   logic [DATA_W-1:0] out_value_ff;
   logic              out_valid_ff;
   logic [ROW_W-1:0]  out_left_ff;

   assign start_in  = tok_in.valid && (tok_in.left != '0);
   assign fin_valid = tok_in.valid && (tok_in.left == '0);
   assign fin_value = tok_in.value;

   assign diff_in = {tok_in.value[DATA_W-1], tok_in.value} - {prev_ff[DATA_W-1], prev_ff};
   assign mag_in  = diff_in[DATA_W] ? (prev_ff - tok_in.value) : diff_in[DATA_W-1:0];

   assign sum_in = SUM_W'({c_phi_ff, {HALF_W{1'b0}}}) + SUM_W'(c_plo_ff) + ROUND_HALF;

   always_comb begin
      if (!d_neg_ff) begin
         res_in = d_base_ff + d_q_ff;
         if (!d_base_ff[DATA_W-1] && res_in[DATA_W-1]) begin
            res_in = SAT_MAX;
         end
      end else begin
         res_in = d_base_ff - d_q_ff;
         if (d_base_ff[DATA_W-1] && !res_in[DATA_W-1]) begin
            res_in = SAT_MIN;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff   <= 1'b0;
         b_valid_ff   <= 1'b0;
         c_valid_ff   <= 1'b0;
         d_valid_ff   <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         a_valid_ff   <= start_in;
         b_valid_ff   <= a_valid_ff;
         c_valid_ff   <= b_valid_ff;
         d_valid_ff   <= c_valid_ff;
         out_valid_ff <= d_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (tok_in.valid) begin
         prev_ff <= tok_in.value;
      end
      a_left_ff    <= tok_in.left - ROW_W'(1);
      a_base_ff    <= tok_in.value;
      a_mag_ff     <= mag_in;
      a_neg_ff     <= diff_in[DATA_W];
      b_left_ff    <= a_left_ff;
      b_base_ff    <= a_base_ff;
      b_neg_ff     <= a_neg_ff;
      b_mhi_ff     <= a_mag_ff[DATA_W-1:HALF_W];
      b_plo_ff     <= PROD_W'(a_mag_ff[HALF_W-1:0]) * PROD_W'(recip);
      c_left_ff    <= b_left_ff;
      c_base_ff    <= b_base_ff;
      c_neg_ff     <= b_neg_ff;
      c_plo_ff     <= b_plo_ff;
      c_phi_ff     <= PROD_W'(b_mhi_ff) * PROD_W'(recip);
      d_left_ff    <= c_left_ff;
      d_base_ff    <= c_base_ff;
      d_neg_ff     <= c_neg_ff;
      d_q_ff       <= sum_in[FRAC_BITS+DATA_W-1:FRAC_BITS];
      out_left_ff  <= d_left_ff;
      out_value_ff <= res_in;
   end

   assign tok_out.valid = out_valid_ff;
   assign tok_out.left  = out_left_ff;
   assign tok_out.value = out_value_ff;

endmodule

`default_nettype wire
